[rtl/lpp_pkg.sv]
package lpp_pkg;

  // Stream constants
  localparam logic [7:0] START_BYTE  = 8'hFA;
  localparam logic [7:0] INDEX_FIRST = 8'hA0;
  localparam logic [7:0] INDEX_LAST  = 8'hDB;
  localparam logic [8:0] ANGLE_TOP   = 9'd359;

  // Packet byte positions
  localparam logic [5:0] PH_HUNT     = 6'd0;
  localparam logic [5:0] PH_INDEX    = 6'd1;
  localparam logic [5:0] PH_SPEED_LO = 6'd2;
  localparam logic [5:0] PH_SPEED_HI = 6'd3;
  localparam logic [5:0] PH_LAST     = 6'd41;

  // Reading layout: intensity lo/hi, range lo/hi, two spare bytes
  localparam logic [2:0] OFF_INT_LO  = 3'd0;
  localparam logic [2:0] OFF_INT_HI  = 3'd1;
  localparam logic [2:0] OFF_RNG_LO  = 3'd2;
  localparam logic [2:0] OFF_RNG_HI  = 3'd3;
  localparam logic [2:0] OFF_LAST    = 3'd5;
  localparam logic [2:0] SLOT_COUNT  = 3'd6;

  // Divide by ten: (x * 52429) >> 19, exact for 16-bit x
  localparam logic [15:0] DIV10_MUL  = 16'd52429;
  localparam int          DIV10_SHR  = 19;

  // Configuration register indexes
  localparam logic [1:0] CFG_LOW_CUT = 2'd0;
  localparam logic [1:0] CFG_MIN_RNG = 2'd1;
  localparam logic [1:0] CFG_MAX_RNG = 2'd2;

  localparam logic        LOW_CUT_RESET   = 1'b1;
  localparam logic [15:0] MIN_RANGE_RESET = 16'd150;
  localparam logic [15:0] MAX_RANGE_RESET = 16'd3500;

  localparam int SNAPSHOT_READINGS = 61;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic        low_cut;
    logic [15:0] min_range;
    logic [15:0] max_range;
  } cfg_t;

  // One raw reading handed from front to back
  typedef struct packed {
    logic [8:0]  angle;
    logic [15:0] range;
    logic [15:0] intensity;
    logic [12:0] rpm;
  } reading_t;

endpackage

[rtl/lpp_front.sv]
module lpp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_valid_i,
  output logic              byte_ready_o,
  input  logic [7:0]        byte_i,
  output logic              push_o,
  output lpp_pkg::reading_t push_data_o,
  input  logic              full_i
);
  import lpp_pkg::*;

  logic [5:0]  phase_q, phase_d;
  logic [2:0]  slot_q, slot_d;
  logic [2:0]  off_q, off_d;
  logic        valid_q, valid_d;
  logic [8:0]  angle_top_q, angle_top_d;
  logic [7:0]  speed_lo_q, speed_lo_d;
  logic [12:0] rpm_q, rpm_d;
  logic [7:0]  int_lo_q, int_lo_d;
  logic [7:0]  int_hi_q, int_hi_d;
  logic [7:0]  rng_lo_q, rng_lo_d;

  logic        accept;
  logic        idx_ok;
  logic [7:0]  idx_off;
  logic [8:0]  base;
  logic [31:0] rpm_prod;
  logic        in_slot;

  assign byte_ready_o = !full_i;
  assign accept       = byte_valid_i && !full_i;

  // Index decode and base angle
  assign idx_ok  = (byte_i >= INDEX_FIRST) && (byte_i <= INDEX_LAST);
  assign idx_off = byte_i - INDEX_FIRST;
  assign base    = 9'({3'b000, idx_off[5:0]} * 9'd6);

  // Speed word / 10 by reciprocal multiply
  assign rpm_prod = {byte_i, speed_lo_q} * DIV10_MUL;

  assign in_slot = (phase_q > PH_SPEED_HI) && (slot_q < SLOT_COUNT);

  // Emit a reading on its range high byte
  assign push_o = accept && in_slot && (off_q == OFF_RNG_HI) && valid_q;
  assign push_data_o = '{
    angle:     angle_top_q - {6'd0, slot_q},
    range:     {byte_i, rng_lo_q},
    intensity: {int_hi_q, int_lo_q},
    rpm:       rpm_q
  };

  // Byte sequencing
  always_comb begin
    phase_d     = phase_q;
    slot_d      = slot_q;
    off_d       = off_q;
    valid_d     = valid_q;
    angle_top_d = angle_top_q;
    speed_lo_d  = speed_lo_q;
    rpm_d       = rpm_q;
    int_lo_d    = int_lo_q;
    int_hi_d    = int_hi_q;
    rng_lo_d    = rng_lo_q;
    if (accept) begin
      phase_d = (phase_q >= PH_LAST) ? PH_HUNT : phase_q + 6'd1;
      case (phase_q)
        PH_HUNT: begin
          phase_d = (byte_i == START_BYTE) ? PH_INDEX : PH_HUNT;
        end
        PH_INDEX: begin
          valid_d = idx_ok;
          if (idx_ok) begin
            angle_top_d = ANGLE_TOP - base;
          end
        end
        PH_SPEED_LO: begin
          speed_lo_d = byte_i;
        end
        PH_SPEED_HI: begin
          rpm_d  = rpm_prod[DIV10_SHR +: 13];
          slot_d = 3'd0;
          off_d  = 3'd0;
        end
        default: begin
          if (in_slot) begin
            case (off_q)
              OFF_INT_LO: int_lo_d = byte_i;
              OFF_INT_HI: int_hi_d = byte_i;
              OFF_RNG_LO: rng_lo_d = byte_i;
              default:    ;
            endcase
            if (off_q == OFF_LAST) begin
              off_d  = 3'd0;
              slot_d = slot_q + 3'd1;
            end else begin
              off_d = off_q + 3'd1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      slot_q      <= '0;
      off_q       <= '0;
      valid_q     <= 1'b0;
      angle_top_q <= '0;
      speed_lo_q  <= '0;
      rpm_q       <= '0;
      int_lo_q    <= '0;
      int_hi_q    <= '0;
      rng_lo_q    <= '0;
    end else begin
      phase_q     <= phase_d;
      slot_q      <= slot_d;
      off_q       <= off_d;
      valid_q     <= valid_d;
      angle_top_q <= angle_top_d;
      speed_lo_q  <= speed_lo_d;
      rpm_q       <= rpm_d;
      int_lo_q    <= int_lo_d;
      int_hi_q    <= int_hi_d;
      rng_lo_q    <= rng_lo_d;
    end
  end

endmodule

[rtl/lpp_queue.sv]
module lpp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lpp_pkg::reading_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output lpp_pkg::reading_t pop_data_o
);
  import lpp_pkg::*;

  reading_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/lpp_back.sv]
module lpp_back #(
  parameter int SnapshotReadings = lpp_pkg::SNAPSHOT_READINGS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lpp_pkg::cfg_t     cfg_i,
  input  logic              valid_i,
  input  lpp_pkg::reading_t data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [8:0]        angle_o,
  output logic [15:0]       distance_o,
  output logic [15:0]       intensity_o,
  output logic [12:0]       rpm_o,
  output logic              no_echo_o,
  output logic              snapshot_o
);
  import lpp_pkg::*;

  localparam int CntW = $clog2(SnapshotReadings);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic [8:0]      angle_q;
  logic [15:0]     dist_q, dist_d;
  logic [15:0]     int_q;
  logic [12:0]     rpm_q;
  logic            no_echo_q;
  logic            snap_q, snap_d;
  logic [15:0]     cut;

  assign pop_o = valid_i && (!out_valid_q || out_ready_i);

  // Low cut, then clamp
  always_comb begin
    cut = data_i.range;
    if (cfg_i.low_cut && (data_i.range < cfg_i.min_range)) begin
      cut = cfg_i.max_range;
    end
    dist_d = (cut > cfg_i.max_range) ? cfg_i.max_range : cut;
  end

  // Snapshot counter
  always_comb begin
    count_d = count_q;
    snap_d  = 1'b0;
    if (pop_o) begin
      if (count_q == CntW'(SnapshotReadings - 1)) begin
        count_d = '0;
        snap_d  = 1'b1;
      end else begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      angle_q   <= data_i.angle;
      dist_q    <= dist_d;
      int_q     <= data_i.intensity;
      rpm_q     <= data_i.rpm;
      no_echo_q <= (dist_d == cfg_i.max_range);
      snap_q    <= snap_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign angle_o     = angle_q;
  assign distance_o  = dist_q;
  assign intensity_o = int_q;
  assign rpm_o       = rpm_q;
  assign no_echo_o   = no_echo_q;
  assign snapshot_o  = snap_q;

endmodule

[rtl/lidar_packet_parser.sv]
// Lidar packet parser: takes the serial byte stream of a spinning lidar one
// byte per request, finds the 0xFA start byte, consumes the 41 bytes after it
// and emits six readings per packet with a valid index (0xA0..0xDB): angle,
// clamped distance, intensity and rpm in tdata, the no-echo flag in tuser and
// the every-Nth-reading snapshot flag in tlast. One byte is accepted in every
// cycle while the queue is not full; each reading goes from the front decode
// through the two-entry queue to the output register. s_axis_tready drops only
// while the two-entry queue is full, i.e. under sustained output backpressure.
// Configuration writes are accepted every cycle and must be made while idle.
module lidar_packet_parser #(
  parameter int SnapshotReadings = lpp_pkg::SNAPSHOT_READINGS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // rx_byte [7:0]
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // angle [8:0], distance [24:9], intensity [40:25], rpm [53:41], zero [55:54]
  output logic [55:0] m_axis_tdata,
  // no_echo [0]
  output logic        m_axis_tuser,
  // snapshot_due
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import lpp_pkg::*;

  cfg_t     cfg_q;
  logic     push;
  reading_t push_data;
  logic     full;
  logic     pop;
  logic     q_valid;
  reading_t q_data;
  logic [8:0]  angle;
  logic [15:0] distance;
  logic [15:0] intensity;
  logic [12:0] rpm;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_cut   <= LOW_CUT_RESET;
      cfg_q.min_range <= MIN_RANGE_RESET;
      cfg_q.max_range <= MAX_RANGE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LOW_CUT: cfg_q.low_cut   <= cfg_data_i[0];
        CFG_MIN_RNG: cfg_q.min_range <= cfg_data_i;
        CFG_MAX_RNG: cfg_q.max_range <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  lpp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .push_o       (push),
    .push_data_o  (push_data),
    .full_i       (full)
  );

  lpp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  lpp_back #(
    .SnapshotReadings (SnapshotReadings)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (q_valid),
    .data_i      (q_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .angle_o     (angle),
    .distance_o  (distance),
    .intensity_o (intensity),
    .rpm_o       (rpm),
    .no_echo_o   (m_axis_tuser),
    .snapshot_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, rpm, intensity, distance, angle};

endmodule

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpp_pkg::*;

  localparam logic [1:0] CFG_UNUSED     = 2'd3;
  localparam int         FIRST_READING  = int'(PH_SPEED_HI) + 1;
  localparam int         READING_STRIDE = int'(OFF_LAST) + 1;
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         RANDOM_BYTES   = 600;

  typedef struct {
    logic [8:0]  angle;
    logic [15:0] distance;
    logic [15:0] intensity;
    logic [12:0] rpm;
    logic        no_echo;
    logic        snapshot;
  } lidar_reading_t;

  logic        clk_i;
  logic        rst_ni;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  lidar_packet_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Shared test state
  int fail_cnt    = 0;
  int n_sent      = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req    = 0;

  // Parser shadow: configuration and packet state
  logic        cfg_low_cut = LOW_CUT_RESET;
  logic [15:0] cfg_min     = MIN_RANGE_RESET;
  logic [15:0] cfg_max     = MAX_RANGE_RESET;
  logic [5:0]  ph          = PH_HUNT;
  logic        pkt_ok      = 1'b0;
  logic [8:0]  base        = '0;
  logic [7:0]  spd_lo      = '0;
  logic [12:0] rpm_q       = '0;
  logic [15:0] int_q       = '0;
  logic [7:0]  rng_lo      = '0;
  int          rd_count    = 0;

  lidar_reading_t pending_readings[$];
  lidar_reading_t head_reading;

  // Advance the packet shadow by one byte; queue a reading on a range high byte
  function automatic void parse_byte(logic [7:0] b);
    int             rel;
    logic [2:0]     slot;
    logic [2:0]     off;
    logic [15:0]    rng_val;
    lidar_reading_t r;
    if (ph == PH_HUNT) begin
      if (b == START_BYTE) ph = PH_INDEX;
      return;
    end
    case (ph)
      PH_INDEX: begin
        pkt_ok = (b >= INDEX_FIRST) && (b <= INDEX_LAST);
        if (pkt_ok) base = 9'((int'(b) - int'(INDEX_FIRST)) * 6);
      end
      PH_SPEED_LO: spd_lo = b;
      PH_SPEED_HI: rpm_q = 13'({b, spd_lo} / 10);
      default: begin
        rel  = int'(ph) - FIRST_READING;
        slot = 3'(rel / READING_STRIDE);
        off  = 3'(rel % READING_STRIDE);
        if (slot < SLOT_COUNT) begin
          case (off)
            OFF_INT_LO: int_q = {8'h00, b};
            OFF_INT_HI: int_q = {b, int_q[7:0]};
            OFF_RNG_LO: rng_lo = b;
            OFF_RNG_HI: begin
              if (pkt_ok) begin
                rng_val = {b, rng_lo};
                if (rng_val < cfg_min && cfg_low_cut) rng_val = cfg_max;
                if (rng_val > cfg_max) rng_val = cfg_max;
                r.snapshot = 1'b0;
                rd_count++;
                if (rd_count >= SNAPSHOT_READINGS) begin
                  rd_count   = 0;
                  r.snapshot = 1'b1;
                end
                r.angle     = ANGLE_TOP - base - 9'(slot);
                r.distance  = rng_val;
                r.intensity = int_q;
                r.rpm       = rpm_q;
                r.no_echo   = (rng_val == cfg_max);
                pending_readings = {pending_readings, r};
              end
            end
            default: ;
          endcase
        end
      end
    endcase
    ph = (ph >= PH_LAST) ? PH_HUNT : ph + 6'd1;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Input side: every accepted byte feeds the shadow parser
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata);
  end

  // Config side: mirror accepted register writes
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LOW_CUT: cfg_low_cut = cfg_data_i[0];
        CFG_MIN_RNG: cfg_min = cfg_data_i;
        CFG_MAX_RNG: cfg_max = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Output side: compare each reading with the oldest one predicted
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_readings.size() == 0) begin
        $error("reading with none predicted: tdata %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        head_reading = pending_readings.pop_front();
        check_field("angle", head_reading.angle, m_axis_tdata[8:0]);
        check_field("distance", head_reading.distance, m_axis_tdata[24:9]);
        check_field("intensity", head_reading.intensity, m_axis_tdata[40:25]);
        check_field("rpm", head_reading.rpm, m_axis_tdata[53:41]);
        check_field("no_echo", head_reading.no_echo, m_axis_tuser);
        check_field("snapshot_due", head_reading.snapshot, m_axis_tlast);
      end
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls plus an on-demand long hold-off
  initial begin
    int stall;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        stall    = hold_req;
        hold_req = 0;
      end else if (stall == 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        stall = gap_len();
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // One byte request; valid stays high afterwards unless a gap follows
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = ($urandom_range(0, 99) < tx_idle_pct) ? gap_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  // Ranges aimed at the low cut and clamp boundaries
  function automatic logic [15:0] pick_range();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return cfg_min - 16'd1;
      3: return cfg_min;
      4: return cfg_max;
      5: return cfg_max + 16'd1;
      6: return 16'($urandom_range(0, 4095));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Full packet with random content and the given index
  task automatic send_packet(input logic [7:0] idx);
    logic [15:0] w;
    send_byte(START_BYTE);
    send_byte(idx);
    w = 16'($urandom_range(0, 65535));
    send_byte(w[7:0]);
    send_byte(w[15:8]);
    for (int s = 0; s < int'(SLOT_COUNT); s++) begin
      w = 16'($urandom_range(0, 65535));
      send_byte(w[7:0]);
      send_byte(w[15:8]);
      w = pick_range();
      send_byte(w[7:0]);
      send_byte(w[15:8]);
      repeat (2) send_byte(($urandom_range(0, 7) == 0) ? START_BYTE
                                                       : 8'($urandom_range(0, 255)));
    end
    repeat (2) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Packet whose body is one repeated byte
  task automatic send_fill_packet(input logic [7:0] idx, input logic [7:0] fill);
    send_byte(START_BYTE);
    send_byte(idx);
    repeat (int'(PH_LAST) - 1) send_byte(fill);
  endtask

  function automatic logic [7:0] pick_index();
    if ($urandom_range(0, 9) != 0) return 8'($urandom_range(INDEX_FIRST, INDEX_LAST));
    return 8'($urandom_range(0, 255));
  endfunction

  // Stop sending, wait for every predicted reading plus the pipeline tail
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    // let the shadow parser see the last accepted byte first
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all registers back to back, then the unused index
  task automatic apply_cfg(input logic lc, input logic [15:0] mn, input logic [15:0] mx);
    logic [1:0]  idx_list[4];
    logic [15:0] val_list[4];
    idx_list = '{CFG_LOW_CUT, CFG_MIN_RNG, CFG_MAX_RNG, CFG_UNUSED};
    val_list = '{{15'($urandom_range(0, 32767)), lc}, mn, mx,
                 16'($urandom_range(0, 65535))};
    cfg_valid_i <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index_i <= idx_list[i];
      cfg_data_i  <= val_list[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_cfg_word();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 4095));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int pick_idle();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 25;
      default: return 60;
    endcase
  endfunction

  // Reset values: noise while hunting, index edges, bad indexes, start byte in body
  task automatic test_reset_defaults();
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hF9);
    send_byte(8'hFB);
    send_fill_packet(INDEX_FIRST, 8'hFF);
    send_fill_packet(INDEX_LAST, 8'h00);
    send_fill_packet(INDEX_FIRST - 8'd1, START_BYTE);
    send_fill_packet(INDEX_LAST + 8'd1, 8'h55);
    send_fill_packet(INDEX_LAST, START_BYTE);
    send_packet(8'hC0);
    settle();
  endtask

  // Register extremes, including min above max
  task automatic test_config_extremes();
    logic        lc_list[6];
    logic [15:0] mn_list[6];
    logic [15:0] mx_list[6];
    lc_list = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    mn_list = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, MIN_RANGE_RESET};
    mx_list = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, MAX_RANGE_RESET};
    for (int i = 0; i < 6; i++) begin
      apply_cfg(lc_list[i], mn_list[i], mx_list[i]);
      repeat (2) send_packet(pick_index());
      settle();
    end
  endtask

  // Long receiver hold-off while the sender pushes packets without gaps
  task automatic test_backpressure();
    tx_idle_pct = 0;
    hold_req    = HOLD_CYCLES;
    repeat (4) send_packet(8'($urandom_range(INDEX_FIRST, INDEX_LAST)));
    settle();
  endtask

  // Random stream: mostly well-formed packets, some noise and cut-off packets
  task automatic test_random_stream();
    int target;
    int r;
    target = n_sent + RANDOM_BYTES;
    while (n_sent < target) begin
      settle();
      if ($urandom_range(0, 2) == 0) begin
        apply_cfg(1'($urandom_range(0, 1)), pick_cfg_word(), pick_cfg_word());
      end
      tx_idle_pct = pick_idle();
      rx_idle_pct = pick_idle();
      repeat ($urandom_range(3, 8)) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          send_packet(pick_index());
        end else if (r < 90) begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_byte(START_BYTE);
          repeat ($urandom_range(1, 41)) send_byte(8'($urandom_range(0, 255)));
        end
      end
    end
    settle();
  endtask

  // Main sequence
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_LOW_CUT;
    cfg_data_i    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_config_extremes();
    test_backpressure();
    test_random_stream();

    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[sim.f]
rtl/lpp_pkg.sv
rtl/lpp_front.sv
rtl/lpp_queue.sv
rtl/lpp_back.sv
rtl/lidar_packet_parser.sv
tb/tb.sv
